// ----- hdl/fwc_pkg.sv -----
package fwc_pkg;

    // Field widths of the item and result beats.
    localparam int SIG_W      = 16;
    localparam int WORD_W     = 32;
    localparam int BYTE_W     = 8;
    localparam int REASON_W   = 3;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    // Depth of the queue between front and back end.
    localparam int QUEUE_AW    = 2;
    localparam int QUEUE_DEPTH = 1 << QUEUE_AW;

    // Item kinds.
    localparam logic KIND_HEADER = 1'b0;
    localparam logic KIND_DATA   = 1'b1;

    // Result codes.
    localparam logic [REASON_W-1:0] REASON_OK           = 3'd0;
    localparam logic [REASON_W-1:0] REASON_BAD_SIG      = 3'd1;
    localparam logic [REASON_W-1:0] REASON_OUT_OF_FLASH = 3'd2;
    localparam logic [REASON_W-1:0] REASON_ZERO_SIZE    = 3'd3;
    localparam logic [REASON_W-1:0] REASON_CRC_MISMATCH = 3'd4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_FLASH_SIZE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_VALID_SIG  = 1'b1;

    // Register reset values.
    localparam logic [WORD_W-1:0] FLASH_SIZE_RST = 32'd131072;
    localparam logic [SIG_W-1:0]  VALID_SIG_RST  = 16'd17241;

    localparam logic [WORD_W-1:0] CRC_ALL_ONES = 32'hFFFF_FFFF;

    // Reflected CRC-32C table, one entry per nibble.
    localparam logic [WORD_W-1:0] NIB_TABLE [16] = '{
        32'h0000_0000, 32'h105e_c76f, 32'h20bd_8ede, 32'h30e3_49b1,
        32'h417b_1dbc, 32'h5125_dad3, 32'h61c6_9362, 32'h7198_540d,
        32'h82f6_3b78, 32'h92a8_fc17, 32'ha24b_b5a6, 32'hb215_72c9,
        32'hc38d_26c4, 32'hd3d3_e1ab, 32'he330_a81a, 32'hf36e_6f75
    };

    // One queue entry: a classified item on its way to the back end.
    typedef struct packed {
        logic                kind;
        logic [REASON_W-1:0] reason;
        logic [WORD_W-1:0]   image_size;
        logic [WORD_W-1:0]   expected_crc;
        logic [BYTE_W-1:0]   data_byte;
    } t_entry;

    // One 4-bit step of the reflected CRC.
    function automatic logic [WORD_W-1:0] crc_nib(input logic [WORD_W-1:0] crc);
        return {4'b0000, crc[WORD_W-1:4]} ^ NIB_TABLE[crc[3:0]];
    endfunction

    // One byte folded into the CRC as two nibble steps.
    function automatic logic [WORD_W-1:0] crc_byte(input logic [WORD_W-1:0] crc,
                                                   input logic [BYTE_W-1:0] b);
        logic [WORD_W-1:0] c;
        c = crc ^ {{(WORD_W-BYTE_W){1'b0}}, b};
        c = crc_nib(c);
        return crc_nib(c);
    endfunction

endpackage

// ----- hdl/fwc_item_if.sv -----
interface fwc_item_if;
    logic                              valid;
    logic                              ready;
    logic                              kind;
    logic [fwc_pkg::SIG_W-1:0]         signature;
    logic [fwc_pkg::WORD_W-1:0]        image_start;
    logic [fwc_pkg::WORD_W-1:0]        image_size;
    logic [fwc_pkg::WORD_W-1:0]        expected_crc;
    logic [fwc_pkg::BYTE_W-1:0]        data_byte;

    modport source (
        output valid, kind, signature, image_start, image_size, expected_crc, data_byte,
        input  ready
    );

    modport sink (
        input  valid, kind, signature, image_start, image_size, expected_crc, data_byte,
        output ready
    );
endinterface

// ----- hdl/fwc_result_if.sv -----
interface fwc_result_if;
    logic                          valid;
    logic                          ready;
    logic                          image_valid;
    logic [fwc_pkg::REASON_W-1:0]  fail_reason;
    logic [fwc_pkg::WORD_W-1:0]    computed_crc;

    modport source (
        output valid, image_valid, fail_reason, computed_crc,
        input  ready
    );

    modport sink (
        input  valid, image_valid, fail_reason, computed_crc,
        output ready
    );
endinterface

// ----- hdl/fwc_front.sv -----
module fwc_front (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    fwc_item_if.sink                          i_item,
    input  logic                              i_cfg_we,
    input  logic [fwc_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [fwc_pkg::CFG_DATA_W-1:0]    i_cfg_wdata,
    input  logic                              i_full,
    output logic                              o_push,
    output fwc_pkg::t_entry                   o_entry
);

    logic [fwc_pkg::WORD_W-1:0] r_flash_size;
    logic [fwc_pkg::SIG_W-1:0]  r_valid_sig;
    logic [fwc_pkg::WORD_W:0]   w_end;
    logic [fwc_pkg::REASON_W-1:0] w_reason;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flash_size <= fwc_pkg::FLASH_SIZE_RST;
            r_valid_sig  <= fwc_pkg::VALID_SIG_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                fwc_pkg::CFG_FLASH_SIZE: r_flash_size <= i_cfg_wdata;
                fwc_pkg::CFG_VALID_SIG:  r_valid_sig  <= i_cfg_wdata[fwc_pkg::SIG_W-1:0];
                default: ;
            endcase
        end
    end

    // Image end address, one bit wider so that it never wraps.
    assign w_end = {1'b0, i_item.image_start} + {1'b0, i_item.image_size};

    // Header checks in priority order.
    always_comb begin
        priority if (i_item.signature != r_valid_sig) begin
            w_reason = fwc_pkg::REASON_BAD_SIG;
        end else if (w_end >= {1'b0, r_flash_size}) begin
            w_reason = fwc_pkg::REASON_OUT_OF_FLASH;
        end else if (i_item.image_size == '0) begin
            w_reason = fwc_pkg::REASON_ZERO_SIZE;
        end else begin
            w_reason = fwc_pkg::REASON_OK;
        end
    end

    // Every beat is taken while the queue has room.
    assign i_item.ready = !i_full;
    assign o_push       = i_item.valid && !i_full;

    assign o_entry.kind         = i_item.kind;
    assign o_entry.reason       = w_reason;
    assign o_entry.image_size   = i_item.image_size;
    assign o_entry.expected_crc = i_item.expected_crc;
    assign o_entry.data_byte    = i_item.data_byte;

endmodule

// ----- hdl/fwc_queue.sv -----
module fwc_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  fwc_pkg::t_entry  i_entry,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_empty,
    output fwc_pkg::t_entry  o_entry
);

    fwc_pkg::t_entry r_mem [fwc_pkg::QUEUE_DEPTH];
    logic [fwc_pkg::QUEUE_AW:0] r_wr_ptr;
    logic [fwc_pkg::QUEUE_AW:0] r_rd_ptr;

    // Pointers carry one wrap bit above the address.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr[fwc_pkg::QUEUE_AW-1:0]] <= i_entry;
        end
    end

    assign o_empty = (r_wr_ptr == r_rd_ptr);
    assign o_full  = (r_wr_ptr[fwc_pkg::QUEUE_AW] != r_rd_ptr[fwc_pkg::QUEUE_AW]) &&
                     (r_wr_ptr[fwc_pkg::QUEUE_AW-1:0] == r_rd_ptr[fwc_pkg::QUEUE_AW-1:0]);
    assign o_entry = r_mem[r_rd_ptr[fwc_pkg::QUEUE_AW-1:0]];

endmodule

// ----- hdl/fwc_back.sv -----
module fwc_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  fwc_pkg::t_entry  i_entry,
    input  logic             i_empty,
    output logic             o_pop,
    fwc_result_if.source     o_result
);

    logic [fwc_pkg::WORD_W-1:0]   r_crc,      n_crc;
    logic [fwc_pkg::WORD_W-1:0]   r_left,     n_left;
    logic [fwc_pkg::WORD_W-1:0]   r_expected, n_expected;
    logic                         r_open,     n_open;
    logic                         r_out_valid, n_out_valid;
    logic                         r_out_ok,   n_out_ok;
    logic [fwc_pkg::REASON_W-1:0] r_out_reason, n_out_reason;
    logic [fwc_pkg::WORD_W-1:0]   r_out_crc,  n_out_crc;
    logic [fwc_pkg::WORD_W-1:0]   w_crc_next;
    logic [fwc_pkg::WORD_W-1:0]   w_final;

    // An entry is taken whenever the result register is free or being emptied.
    assign o_pop = !i_empty && (!r_out_valid || o_result.ready);

    assign w_crc_next = fwc_pkg::crc_byte(r_crc, i_entry.data_byte);
    assign w_final    = ~w_crc_next;

    // Carry out one queue entry.
    always_comb begin
        n_crc        = r_crc;
        n_left       = r_left;
        n_expected   = r_expected;
        n_open       = r_open;
        n_out_valid  = r_out_valid && !o_result.ready;
        n_out_ok     = r_out_ok;
        n_out_reason = r_out_reason;
        n_out_crc    = r_out_crc;
        if (o_pop) begin
            unique case (i_entry.kind)
                fwc_pkg::KIND_HEADER: begin
                    if (i_entry.reason != fwc_pkg::REASON_OK) begin
                        // Rejected header closes any open image and reports.
                        n_open       = 1'b0;
                        n_left       = '0;
                        n_out_valid  = 1'b1;
                        n_out_ok     = 1'b0;
                        n_out_reason = i_entry.reason;
                        n_out_crc    = '0;
                    end else begin
                        n_crc      = fwc_pkg::CRC_ALL_ONES;
                        n_left     = i_entry.image_size;
                        n_expected = i_entry.expected_crc;
                        n_open     = 1'b1;
                    end
                end
                fwc_pkg::KIND_DATA: begin
                    if (r_open) begin
                        n_crc  = w_crc_next;
                        n_left = r_left - 1'b1;
                        // The last byte closes the image and reports the check.
                        if (r_left == {{(fwc_pkg::WORD_W-1){1'b0}}, 1'b1}) begin
                            n_open       = 1'b0;
                            n_out_valid  = 1'b1;
                            n_out_ok     = (w_final == r_expected);
                            n_out_reason = (w_final == r_expected) ?
                                           fwc_pkg::REASON_OK : fwc_pkg::REASON_CRC_MISMATCH;
                            n_out_crc    = w_final;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc       <= fwc_pkg::CRC_ALL_ONES;
            r_left      <= '0;
            r_expected  <= '0;
            r_open      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_crc       <= n_crc;
            r_left      <= n_left;
            r_expected  <= n_expected;
            r_open      <= n_open;
            r_out_valid <= n_out_valid;
        end
    end

    // Result payload holds while the receiver stalls.
    always_ff @(posedge i_clk) begin
        r_out_ok     <= n_out_ok;
        r_out_reason <= n_out_reason;
        r_out_crc    <= n_out_crc;
    end

    assign o_result.valid        = r_out_valid;
    assign o_result.image_valid  = r_out_ok;
    assign o_result.fail_reason  = r_out_reason;
    assign o_result.computed_crc = r_out_crc;

endmodule

// ----- hdl/firmware_image_crc32c_validator.sv -----
// Firmware image check with CRC-32C.
// The item channel carries one beat per header or image byte. A header beat
// (kind 0) is checked at once against the signature and flash size registers
// and for zero size; a rejected header gives one result beat with image_valid
// 0 and CRC 0. An accepted header opens an image of image_size bytes; data
// beats (kind 1) are folded into the CRC and the last one gives one result
// beat: valid, or CRC mismatch. Data beats with no open image are dropped.
// Throughput: one item beat per cycle while the queue has room; the byte CRC
// step in the back end is combinational. An accepted beat is written into the
// queue, then taken by the back end, which writes any result to its register.
// The front end classifies beats into a four-entry queue; the back end drains
// it into a result register. When the receiver stalls, the result holds, the
// queue fills, and the item channel drops ready once the queue is full.
// Configuration must be written through the write port while idle; this is
// not enforced. Reset (synchronous, active low) closes any image, empties the
// queue and loads the register defaults: flash size 131072, signature 17241.
module firmware_image_crc32c_validator (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    fwc_item_if.sink                          i_item,
    fwc_result_if.source                      o_result,
    input  logic                              i_cfg_we,
    input  logic [fwc_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [fwc_pkg::CFG_DATA_W-1:0]    i_cfg_wdata
);

    logic            w_push;
    logic            w_pop;
    logic            w_full;
    logic            w_empty;
    fwc_pkg::t_entry w_entry_in;
    fwc_pkg::t_entry w_entry_out;

    fwc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (i_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_full      (w_full),
        .o_push      (w_push),
        .o_entry     (w_entry_in)
    );

    fwc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_entry_in),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_empty (w_empty),
        .o_entry (w_entry_out)
    );

    fwc_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_entry  (w_entry_out),
        .i_empty  (w_empty),
        .o_pop    (w_pop),
        .o_result (o_result)
    );

    // The back end never takes from an empty queue.
    a_pop_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_empty)
        else $error("queue popped while empty");

    // An accepted beat is in the queue in the next cycle.
    a_accept_queued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_item.valid && i_item.ready) |=> !w_empty)
        else $error("accepted beat missing from queue");

    // The valid flag and the reason code agree.
    a_valid_reason: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid |->
            (o_result.image_valid == (o_result.fail_reason == fwc_pkg::REASON_OK)))
        else $error("image_valid disagrees with fail_reason");

    // Header rejections report a zero CRC.
    a_reject_zero_crc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && (o_result.fail_reason == fwc_pkg::REASON_BAD_SIG ||
                            o_result.fail_reason == fwc_pkg::REASON_OUT_OF_FLASH ||
                            o_result.fail_reason == fwc_pkg::REASON_ZERO_SIZE))
        |-> (o_result.computed_crc == '0))
        else $error("rejected header with nonzero CRC");

endmodule
